// ===== rtl/bdgn_pkg.sv =====
package bdgn_pkg;

    localparam int          CoordW = 32;
    localparam int          ClsW   = 16;
    localparam int          AreaW  = 48;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic signed [CoordW-1:0] x0;
        logic signed [CoordW-1:0] y0;
        logic signed [CoordW-1:0] x1;
        logic signed [CoordW-1:0] y1;
        logic signed [CoordW-1:0] score;
        logic signed [ClsW-1:0]   cls;
    } box_t;

    localparam int BoxW = $bits(box_t);

    function automatic logic [32:0] span(input logic signed [31:0] lo,
                                         input logic signed [31:0] hi);
        logic [32:0] d;
        d = {hi[31], hi} - {lo[31], lo};
        return (hi > lo) ? d : 33'd0;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic fits;
        fits = (&v[48:31]) || !(|v[48:31]);
        if (fits) begin
            return v[31:0];
        end
        return v[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== rtl/bdgn_ram.sv =====
module bdgn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/box_decode_greedy_nms_core.sv =====
// channel | ports                      | contents
// input   | s_tvalid s_tready s_tdata  | one request: kind in s_tuser, box and read index
// output  | m_tvalid m_tready m_tdata  | kept count, corners, score, class, overflow
// config  | cfg_wr_en cfg_addr         | 0 width, 1 height, 2 IoU limit, 3 keep limit
// A load passes through the score divider, which gives one quotient bit per cycle.
// A finish runs an insertion sort over the box memory and then greedy
// suppression that compares each candidate with the kept boxes.
// A read looks up the kept list and then the box memory.
// Reset is synchronous; no clearing pass. The input is taken again while a
// result still waits at the output register.
module box_decode_greedy_nms_core import bdgn_pkg::*; #(
    parameter int MAX_BOXES = 1024,
    parameter int MAX_KEPT  = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // center_x, center_y, box_width, box_height, objectness, class_value, read_index
    input  logic [199:0] s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // kept_count, corner_x0, corner_y0, corner_x1, corner_y1, box_score, class_id,
    // overflow_flag
    output logic [191:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    localparam int AW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW  = $clog2(MAX_BOXES + 1);
    localparam int KAW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int KCW = $clog2(MAX_KEPT + 1);

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_IOU    = 2'd2;
    localparam logic [1:0] REG_KEEP   = 2'd3;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LD_MUL  = 5'd1;
    localparam logic [4:0] S_LD_SAT  = 5'd2;
    localparam logic [4:0] S_LD_AREA = 5'd3;
    localparam logic [4:0] S_LD_DIV  = 5'd4;
    localparam logic [4:0] S_LD_WR   = 5'd5;
    localparam logic [4:0] S_SO_I    = 5'd6;
    localparam logic [4:0] S_SO_IW   = 5'd7;
    localparam logic [4:0] S_SO_J    = 5'd8;
    localparam logic [4:0] S_SO_JW   = 5'd9;
    localparam logic [4:0] S_SO_JC   = 5'd10;
    localparam logic [4:0] S_SU_I    = 5'd11;
    localparam logic [4:0] S_SU_IW   = 5'd12;
    localparam logic [4:0] S_SU_CW   = 5'd13;
    localparam logic [4:0] S_SU_CA   = 5'd14;
    localparam logic [4:0] S_SU_K    = 5'd15;
    localparam logic [4:0] S_SU_KW   = 5'd16;
    localparam logic [4:0] S_SU_KB   = 5'd17;
    localparam logic [4:0] S_SU_KI   = 5'd18;
    localparam logic [4:0] S_SU_KO   = 5'd19;
    localparam logic [4:0] S_SU_KA   = 5'd20;
    localparam logic [4:0] S_SU_KS   = 5'd21;
    localparam logic [4:0] S_SU_KP   = 5'd22;
    localparam logic [4:0] S_SU_KC   = 5'd23;
    localparam logic [4:0] S_RD_A    = 5'd24;
    localparam logic [4:0] S_RD_B    = 5'd25;
    localparam logic [4:0] S_RD_C    = 5'd26;
    localparam logic [4:0] S_OUT     = 5'd27;

    logic [4:0]  state_reg;
    logic [13:0] img_w_reg, img_h_reg;
    logic [15:0] iou_reg;
    logic [7:0]  keep_reg;

    logic [CW-1:0]  box_count_reg;
    logic [KCW-1:0] kept_total_reg;
    logic [KCW-1:0] limit_reg;
    logic           overflow_reg;
    logic           m_tvalid_reg;
    logic [191:0]   m_tdata_reg;
    logic           has_box_reg;

    logic signed [31:0] cx_reg, cy_reg, w_reg, h_reg, obj_reg, cv_reg;
    logic [6:0]         ri_reg;

    logic signed [48:0] px0_reg, py0_reg, px1_reg, py1_reg;
    logic [27:0]        div_reg;
    logic [47:0]        dvd_reg, q_reg;
    logic [28:0]        rem_reg;
    logic [5:0]         cnt_reg;

    box_t               cand_reg, oth_reg;
    logic [CW-1:0]      i_reg, j_reg;
    logic [KCW-1:0]     k_reg;
    logic [AW-1:0]      oidx_reg, cidx_reg;
    logic signed [31:0] key_reg;
    logic [AreaW-1:0]   ca_reg, oa_reg, inter_reg;
    logic [32:0]        isx_reg, isy_reg;
    logic [49:0]        d_reg;
    logic [65:0]        prod_reg;

    logic            st_we;
    logic [AW-1:0]   st_waddr, st_raddr;
    logic [BoxW-1:0] st_wdata, st_rdata;
    logic            or_we;
    logic [AW-1:0]   or_waddr, or_raddr, or_wdata, or_rdata;
    logic            kp_we;
    logic [KAW-1:0]  kp_waddr, kp_raddr;
    logic [AW-1:0]   kp_wdata, kp_rdata;

    box_t st_box;
    assign st_box = box_t'(st_rdata);

    logic [13:0] dim_w, dim_h;
    assign dim_w = (img_w_reg == 14'd0) ? 14'd1 : img_w_reg;
    assign dim_h = (img_h_reg == 14'd0) ? 14'd1 : img_h_reg;

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // shared area multiplier
    logic [32:0]      mul_a, mul_b;
    logic [65:0]      mul_p;
    logic [AreaW-1:0] area_w;
    always_comb begin
        case (state_reg)
            S_SU_KO: begin
                mul_a = isx_reg;
                mul_b = isy_reg;
            end
            S_SU_KA: begin
                mul_a = span(oth_reg.x0, oth_reg.x1);
                mul_b = span(oth_reg.y0, oth_reg.y1);
            end
            default: begin
                mul_a = span(cand_reg.x0, cand_reg.x1);
                mul_b = span(cand_reg.y0, cand_reg.y1);
            end
        endcase
        mul_p  = mul_a * mul_b;
        area_w = mul_p[63:16];
    end

    // corner products
    logic               norm;
    logic signed [14:0] sx, sy;
    logic signed [33:0] tx0, tx1, ty0, ty1;
    always_comb begin
        norm = (cx_reg <= Q_ONE) && (cy_reg <= Q_ONE) && (w_reg <= Q_ONE) && (h_reg <= Q_ONE);
        sx   = norm ? $signed({1'b0, dim_w}) : 15'sd1;
        sy   = norm ? $signed({1'b0, dim_h}) : 15'sd1;
        tx0  = $signed({cx_reg[31], cx_reg, 1'b0}) - $signed({{2{w_reg[31]}}, w_reg});
        tx1  = $signed({cx_reg[31], cx_reg, 1'b0}) + $signed({{2{w_reg[31]}}, w_reg});
        ty0  = $signed({cy_reg[31], cy_reg, 1'b0}) - $signed({{2{h_reg[31]}}, h_reg});
        ty1  = $signed({cy_reg[31], cy_reg, 1'b0}) + $signed({{2{h_reg[31]}}, h_reg});
    end

    // class rounding
    logic [31:0]        cls_mag;
    logic [32:0]        cls_sum;
    logic [16:0]        cls_rnd;
    logic signed [15:0] cls_val;
    always_comb begin
        cls_mag = cv_reg[31] ? (~cv_reg + 32'd1) : cv_reg;
        cls_sum = {1'b0, cls_mag} + 33'd32768;
        cls_rnd = cls_sum[32:16];
        if (cv_reg[31]) begin
            cls_val = $signed(~cls_rnd[15:0] + 16'd1);
        end else if (cls_rnd[15] || cls_rnd[16]) begin
            cls_val = 16'sh7FFF;
        end else begin
            cls_val = $signed(cls_rnd[15:0]);
        end
    end

    // divider step and score
    logic [28:0]        trial;
    logic               qbit;
    logic [30:0]        qsat;
    logic signed [31:0] qs;
    always_comb begin
        trial = {rem_reg[27:0], dvd_reg[47]};
        qbit  = (trial >= {1'b0, div_reg});
        qsat  = (|q_reg[47:31]) ? 31'h7FFF_FFFF : q_reg[30:0];
        qs    = $signed({1'b0, qsat});
    end

    // memory ports
    always_comb begin
        st_we    = 1'b0;
        st_waddr = box_count_reg[AW-1:0];
        st_wdata = {cand_reg.x0, cand_reg.y0, cand_reg.x1, cand_reg.y1,
                    smax(qs, obj_reg), cand_reg.cls};
        st_raddr = i_reg[AW-1:0];
        or_we    = 1'b0;
        or_waddr = j_reg[AW-1:0];
        or_wdata = i_reg[AW-1:0];
        or_raddr = i_reg[AW-1:0];
        kp_we    = 1'b0;
        kp_waddr = kept_total_reg[KAW-1:0];
        kp_wdata = cidx_reg;
        kp_raddr = k_reg[KAW-1:0];
        case (state_reg)
            S_LD_WR: st_we = 1'b1;
            S_SO_J: begin
                or_raddr = AW'(j_reg - CW'(1));
                or_we    = (j_reg == '0);
            end
            S_SO_JW: st_raddr = or_rdata;
            S_SO_JC: begin
                or_we = 1'b1;
                if (st_box.score < key_reg) begin
                    or_wdata = oidx_reg;
                end
            end
            S_SU_IW: st_raddr = or_rdata;
            S_SU_K:  kp_we    = (k_reg == kept_total_reg);
            S_SU_KW: st_raddr = kp_rdata;
            S_RD_A:  kp_raddr = KAW'(ri_reg);
            S_RD_B:  st_raddr = kp_rdata;
            default: ;
        endcase
    end

    bdgn_ram #(.WIDTH(BoxW), .DEPTH(MAX_BOXES)) u_store (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    bdgn_ram #(.WIDTH(AW), .DEPTH(MAX_BOXES)) u_order (
        .aclk(aclk), .we(or_we), .waddr(or_waddr), .wdata(or_wdata),
        .raddr(or_raddr), .rdata(or_rdata)
    );

    bdgn_ram #(.WIDTH(AW), .DEPTH(MAX_KEPT)) u_kept (
        .aclk(aclk), .we(kp_we), .waddr(kp_waddr), .wdata(kp_wdata),
        .raddr(kp_raddr), .rdata(kp_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            img_w_reg      <= 14'd640;
            img_h_reg      <= 14'd640;
            iou_reg        <= 16'd29491;
            keep_reg       <= 8'd100;
            box_count_reg  <= '0;
            kept_total_reg <= '0;
            overflow_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_WIDTH:  img_w_reg <= cfg_wdata[13:0];
                    REG_HEIGHT: img_h_reg <= cfg_wdata[13:0];
                    REG_IOU:    iou_reg   <= cfg_wdata;
                    REG_KEEP:   keep_reg  <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cx_reg  <= s_tdata[31:0];
                        cy_reg  <= s_tdata[63:32];
                        w_reg   <= s_tdata[95:64];
                        h_reg   <= s_tdata[127:96];
                        obj_reg <= s_tdata[159:128];
                        cv_reg  <= s_tdata[191:160];
                        ri_reg  <= s_tdata[198:192];
                        case (s_tuser)
                            KIND_LOAD: begin
                                if (box_count_reg == CW'(MAX_BOXES)) begin
                                    overflow_reg <= 1'b1;
                                end else begin
                                    state_reg <= S_LD_MUL;
                                end
                            end
                            KIND_FINISH: begin
                                i_reg          <= '0;
                                kept_total_reg <= '0;
                                if (keep_reg == 8'd0) begin
                                    limit_reg <= KCW'(1);
                                end else if (int'(keep_reg) > MAX_KEPT) begin
                                    limit_reg <= KCW'(MAX_KEPT);
                                end else begin
                                    limit_reg <= KCW'(keep_reg);
                                end
                                state_reg <= S_SO_I;
                            end
                            KIND_READ: begin
                                has_box_reg <= 1'b0;
                                if (s_tdata[198:192] < kept_total_reg) begin
                                    state_reg <= S_RD_A;
                                end else begin
                                    state_reg <= S_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LD_MUL: begin
                    px0_reg      <= tx0 * sx;
                    px1_reg      <= tx1 * sx;
                    py0_reg      <= ty0 * sy;
                    py1_reg      <= ty1 * sy;
                    cand_reg.cls <= cls_val;
                    div_reg      <= dim_w * dim_h;
                    state_reg    <= S_LD_SAT;
                end
                S_LD_SAT: begin
                    cand_reg.x0 <= sat32(px0_reg >>> 1);
                    cand_reg.x1 <= sat32(px1_reg >>> 1);
                    cand_reg.y0 <= sat32(py0_reg >>> 1);
                    cand_reg.y1 <= sat32(py1_reg >>> 1);
                    state_reg   <= S_LD_AREA;
                end
                S_LD_AREA: begin
                    dvd_reg   <= area_w;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_LD_DIV;
                end
                S_LD_DIV: begin
                    rem_reg <= qbit ? (trial - {1'b0, div_reg}) : trial;
                    q_reg   <= {q_reg[46:0], qbit};
                    dvd_reg <= {dvd_reg[46:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd47) begin
                        state_reg <= S_LD_WR;
                    end
                end
                S_LD_WR: begin
                    box_count_reg <= box_count_reg + CW'(1);
                    state_reg     <= S_IDLE;
                end
                S_SO_I: begin
                    if (i_reg == box_count_reg) begin
                        i_reg     <= '0;
                        state_reg <= S_SU_I;
                    end else begin
                        state_reg <= S_SO_IW;
                    end
                end
                S_SO_IW: begin
                    key_reg   <= st_box.score;
                    j_reg     <= i_reg;
                    state_reg <= S_SO_J;
                end
                S_SO_J: begin
                    if (j_reg == '0) begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_SO_I;
                    end else begin
                        state_reg <= S_SO_JW;
                    end
                end
                S_SO_JW: begin
                    oidx_reg  <= or_rdata;
                    state_reg <= S_SO_JC;
                end
                S_SO_JC: begin
                    if (st_box.score < key_reg) begin
                        j_reg     <= j_reg - CW'(1);
                        state_reg <= S_SO_J;
                    end else begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_SO_I;
                    end
                end
                S_SU_I: begin
                    if (i_reg == box_count_reg || kept_total_reg >= limit_reg) begin
                        has_box_reg <= 1'b0;
                        state_reg   <= S_OUT;
                    end else begin
                        state_reg <= S_SU_IW;
                    end
                end
                S_SU_IW: begin
                    cidx_reg  <= or_rdata;
                    state_reg <= S_SU_CW;
                end
                S_SU_CW: begin
                    cand_reg  <= st_box;
                    state_reg <= S_SU_CA;
                end
                S_SU_CA: begin
                    ca_reg    <= area_w;
                    k_reg     <= '0;
                    state_reg <= S_SU_K;
                end
                S_SU_K: begin
                    if (k_reg == kept_total_reg) begin
                        kept_total_reg <= kept_total_reg + KCW'(1);
                        i_reg          <= i_reg + CW'(1);
                        state_reg      <= S_SU_I;
                    end else begin
                        state_reg <= S_SU_KW;
                    end
                end
                S_SU_KW: state_reg <= S_SU_KB;
                S_SU_KB: begin
                    oth_reg   <= st_box;
                    state_reg <= S_SU_KI;
                end
                S_SU_KI: begin
                    isx_reg   <= span(smax(cand_reg.x0, oth_reg.x0), smin(cand_reg.x1, oth_reg.x1));
                    isy_reg   <= span(smax(cand_reg.y0, oth_reg.y0), smin(cand_reg.y1, oth_reg.y1));
                    state_reg <= S_SU_KO;
                end
                S_SU_KO: begin
                    inter_reg <= area_w;
                    state_reg <= S_SU_KA;
                end
                S_SU_KA: begin
                    oa_reg    <= area_w;
                    state_reg <= S_SU_KS;
                end
                S_SU_KS: begin
                    d_reg     <= {2'b0, ca_reg} + {2'b0, oa_reg} - {2'b0, inter_reg} + 50'd1;
                    state_reg <= S_SU_KP;
                end
                S_SU_KP: begin
                    prod_reg  <= iou_reg * d_reg;
                    state_reg <= S_SU_KC;
                end
                S_SU_KC: begin
                    if ({2'b0, inter_reg, 16'h0} > prod_reg) begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_SU_I;
                    end else begin
                        k_reg     <= k_reg + KCW'(1);
                        state_reg <= S_SU_K;
                    end
                end
                S_RD_A: state_reg <= S_RD_B;
                S_RD_B: state_reg <= S_RD_C;
                S_RD_C: begin
                    cand_reg    <= st_box;
                    has_box_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (has_box_reg) begin
                            m_tdata_reg <= {7'd0, overflow_reg, cand_reg.cls, cand_reg.score,
                                            cand_reg.y1, cand_reg.x1, cand_reg.y0, cand_reg.x0,
                                            8'(kept_total_reg)};
                        end else begin
                            m_tdata_reg <= {7'd0, overflow_reg, 176'd0, 8'(kept_total_reg)};
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== dv/tb_box_decode_greedy_nms_core.sv =====
`timescale 1ns / 1ps

module tb_box_decode_greedy_nms_core;
    import bdgn_pkg::*;

    localparam int BOX_CAP     = 1024;
    localparam int KEEP_CAP    = 128;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int HOLD_CYCLES = 2000;
    localparam int DRAIN_WAIT  = 200;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NOP    = 2'd3
    } kind_e;

    typedef enum logic [1:0] {
        REG_IMG_W    = 2'd0,
        REG_IMG_H    = 2'd1,
        REG_IOU      = 2'd2,
        REG_KEEP_MAX = 2'd3
    } reg_e;

    typedef struct {
        kind_e             kind;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] w;
        logic signed [31:0] h;
        logic signed [31:0] obj;
        logic signed [31:0] cv;
        logic [6:0]         ri;
    } req_t;

    typedef struct {
        logic [7:0]         kept;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] score;
        logic signed [15:0] cls;
        logic               ovf;
    } resp_t;

    typedef struct {
        req_t  r;
        bit    typed;
        resp_t exp;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic         cfg_wr_en;
    logic [1:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    box_decode_greedy_nms_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    box_t        box_mem   [BOX_CAP];
    int unsigned order_mem [BOX_CAP];
    int unsigned kept_mem  [KEEP_CAP];
    int unsigned box_total;
    int unsigned kept_num;
    bit          overflow_seen;
    int unsigned img_w, img_h, iou_q, keep_max;

    resp_t       exp_q [$];
    int          errors;
    int          results_seen;
    longint      cycle_cnt;
    int          send_burst;
    int          recv_burst;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned nonzero(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (v < -longint'(64'h8000_0000)) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] extent(longint lo, longint hi);
        return (hi > lo) ? 64'(hi - lo) : 64'd0;
    endfunction

    function automatic logic [63:0] rect_area(longint x0, longint y0, longint x1, longint y1);
        logic [63:0] p;
        p = extent(x0, x1) * extent(y0, y1);
        return p >> 16;
    endfunction

    function automatic box_t decode_box(req_t r);
        box_t        b;
        longint      cx, cy, w, h, obj, cv, sx, sy, c;
        logic [63:0] area, q;
        bit          norm;
        cx = r.cx;
        cy = r.cy;
        w = r.w;
        h = r.h;
        obj = r.obj;
        cv = r.cv;
        norm = (cx <= 65536) && (cy <= 65536) && (w <= 65536) && (h <= 65536);
        sx = norm ? longint'(nonzero(img_w)) : 1;
        sy = norm ? longint'(nonzero(img_h)) : 1;
        b.x0 = clip32(((2 * cx - w) * sx) >>> 1);
        b.y0 = clip32(((2 * cy - h) * sy) >>> 1);
        b.x1 = clip32(((2 * cx + w) * sx) >>> 1);
        b.y1 = clip32(((2 * cy + h) * sy) >>> 1);
        area = rect_area(b.x0, b.y0, b.x1, b.y1);
        q = area / (64'(nonzero(img_w)) * 64'(nonzero(img_h)));
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        b.score = (longint'(q) > obj) ? q[31:0] : r.obj;
        if (cv >= 0) c = (cv + 32768) >>> 16;
        else c = -((-cv + 32768) >>> 16);
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        b.cls = c[15:0];
        return b;
    endfunction

    function automatic bit too_close(box_t a, box_t b);
        longint      ix0, iy0, ix1, iy1;
        logic [63:0] inter, d;
        logic [95:0] lhs, rhs;
        ix0 = (a.x0 > b.x0) ? a.x0 : b.x0;
        iy0 = (a.y0 > b.y0) ? a.y0 : b.y0;
        ix1 = (a.x1 < b.x1) ? a.x1 : b.x1;
        iy1 = (a.y1 < b.y1) ? a.y1 : b.y1;
        inter = rect_area(ix0, iy0, ix1, iy1);
        d = rect_area(a.x0, a.y0, a.x1, a.y1) + rect_area(b.x0, b.y0, b.x1, b.y1) - inter + 1;
        lhs = 96'(inter) << 16;
        rhs = 96'(iou_q) * 96'(d);
        return lhs > rhs;
    endfunction

    function automatic void run_nms();
        int unsigned i, j, k, lim;
        bit          drop;
        for (i = 0; i < box_total; i++) begin
            j = i;
            while (j > 0 && box_mem[order_mem[j-1]].score < box_mem[i].score) begin
                order_mem[j] = order_mem[j-1];
                j--;
            end
            order_mem[j] = i;
        end
        lim = nonzero(keep_max);
        if (lim > KEEP_CAP) lim = KEEP_CAP;
        kept_num = 0;
        for (i = 0; i < box_total && kept_num < lim; i++) begin
            drop = 0;
            for (k = 0; k < kept_num && !drop; k++)
                drop = too_close(box_mem[order_mem[i]], box_mem[kept_mem[k]]);
            if (!drop) begin
                kept_mem[kept_num] = order_mem[i];
                kept_num++;
            end
        end
    endfunction

    function automatic bit nms_predict(req_t r, output resp_t o);
        box_t b;
        o = '{default: 0};
        case (r.kind)
            KIND_LOAD: begin
                if (box_total >= BOX_CAP) begin
                    overflow_seen = 1;
                end else begin
                    box_mem[box_total] = decode_box(r);
                    box_total++;
                end
                return 0;
            end
            KIND_NOP: return 0;
            KIND_FINISH: run_nms();
            default: ;
        endcase
        o.kept = kept_num[7:0];
        o.ovf = overflow_seen;
        if (r.kind == KIND_READ && r.ri < kept_num) begin
            b = box_mem[kept_mem[r.ri]];
            o.x0 = b.x0;
            o.y0 = b.y0;
            o.x1 = b.x1;
            o.y1 = b.y1;
            o.score = b.score;
            o.cls = b.cls;
        end
        return 1;
    endfunction

    function automatic void reg_apply(reg_e idx, logic [15:0] v);
        case (idx)
            REG_IMG_W:    img_w = v[13:0];
            REG_IMG_H:    img_h = v[13:0];
            REG_IOU:      iou_q = v;
            REG_KEEP_MAX: keep_max = v[7:0];
        endcase
    endfunction

    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            burst = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic req_t mk(kind_e k, logic [31:0] cx, logic [31:0] cy, logic [31:0] w,
                                logic [31:0] h, logic [31:0] obj, logic [31:0] cv,
                                logic [6:0] ri);
        req_t r;
        r.kind = k;
        r.cx = cx;
        r.cy = cy;
        r.w = w;
        r.h = h;
        r.obj = obj;
        r.cv = cv;
        r.ri = ri;
        return r;
    endfunction

    // call at a rising edge; returns at the edge that accepts the request
    task automatic send_req(req_t r, bit typed, resp_t typed_exp);
        int    gap;
        resp_t o;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.ri, r.cv, r.obj, r.h, r.w, r.cy, r.cx};
        s_tuser  <= r.kind;
        do @(posedge aclk); while (!s_tready);
        if (nms_predict(r, o)) exp_q.push_back(typed ? typed_exp : o);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (exp_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_regs(logic [15:0] vw, logic [15:0] vh, logic [15:0] vi,
                              logic [15:0] vk);
        logic [15:0] vals [4];
        vals = '{vw, vh, vi, vk};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= reg_e'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            reg_apply(reg_e'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
            errors++;
        end
    endtask

    task automatic check_resp(resp_t a);
        resp_t e;
        if (exp_q.size() == 0) begin
            $display("%0t: unexpected result %p", $time, a);
            errors++;
            return;
        end
        e = exp_q.pop_front();
        check_field("kept_count", e.kept, a.kept);
        check_field("corner_x0", e.x0, a.x0);
        check_field("corner_y0", e.y0, a.y0);
        check_field("corner_x1", e.x1, a.x1);
        check_field("corner_y1", e.y1, a.y1);
        check_field("box_score", e.score, a.score);
        check_field("class_id", 32'(e.cls), 32'(a.cls));
        check_field("overflow_flag", e.ovf, a.ovf);
    endtask

    // receiver
    initial begin
        int    stall;
        bit    held;
        resp_t a;
        m_tready = 1'b0;
        held = 0;
        recv_burst = 0;
        repeat (4) @(posedge aclk);
        forever begin
            if (!held && results_seen >= 30) begin
                held = 1;
                stall = HOLD_CYCLES;
            end else begin
                stall = draw_wait(recv_burst);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            a.kept  = m_tdata[7:0];
            a.x0    = m_tdata[39:8];
            a.y0    = m_tdata[71:40];
            a.x1    = m_tdata[103:72];
            a.y1    = m_tdata[135:104];
            a.score = m_tdata[167:136];
            a.cls   = m_tdata[183:168];
            a.ovf   = m_tdata[184];
            check_resp(a);
            results_seen++;
        end
    end

    // sender
    initial begin
        dir_row_t    dir_tab [$];
        resp_t       zero_resp;
        req_t        r;
        int          nl, nr, bx, by;
        logic [15:0] vw, vh, vi, vk;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        errors = 0;
        results_seen = 0;
        cycle_cnt = 0;
        send_burst = 0;
        box_total = 0;
        kept_num = 0;
        overflow_seen = 0;
        img_w = 640;
        img_h = 640;
        iou_q = 29491;
        keep_max = 100;
        zero_resp = '{default: 0};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_tab.push_back('{mk(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0), 1, zero_resp});
        dir_tab.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0, 0, 0), 1, zero_resp});
        dir_tab.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0, 0, 127), 1, zero_resp});
        dir_tab.push_back('{mk(KIND_NOP, '1, '1, '1, '1, '1, '1, '1), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 32'h8000, 32'h8000, 32'h4000, 32'h4000,
                               32'hE666, 32'h0002_8000, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 32'h8500, 32'h8200, 32'h4000, 32'h4000,
                               32'hE000, 32'hFFFD_8000, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 0, 0, 0, 0, 0, 0, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 32'h0064_0000, 32'h0032_0000, 32'h0028_0000,
                               32'h001E_0000, 0, 32'h0000_7FFF, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 32'h0064_0000, 32'h0032_0000, 32'h0028_0000,
                               32'h001E_0000, 32'h100, 32'hFFFF_8000, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 32'h0064_0000, 32'h0032_0000, 32'hFFD8_0000,
                               32'h001E_0000, 32'h50, 32'h0001_0000, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                               32'h10, 32'h8000_0000, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_LOAD, 32'h1_0001, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                               32'h20, 32'h7FFF_8000, 0), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0), 0, zero_resp});
        for (int i = 0; i < 9; i++)
            dir_tab.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0, 0, i), 0, zero_resp});
        dir_tab.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0, 0, 127), 0, zero_resp});
        foreach (dir_tab[i]) send_req(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].exp);

        for (int ph = 0; ph < 24; ph++) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: begin vw = 1; vh = 8192; end
                1: begin vw = 8192; vh = 1; end
                2: begin vw = 0; vh = 0; end
                default: begin vw = $urandom_range(1, 8192); vh = $urandom_range(1, 8192); end
            endcase
            case ($urandom_range(0, 3))
                0: vi = 0;
                1: vi = 16'hFFFF;
                default: vi = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 5))
                0: vk = 1;
                1: vk = 128;
                2: vk = 0;
                3: vk = 200;
                default: vk = $urandom_range(1, 16);
            endcase
            write_regs(vw, vh, vi, vk);

            nl = $urandom_range(0, 8);
            bx = $urandom_range(0, 2000);
            by = $urandom_range(0, 2000);
            for (int i = 0; i < nl; i++) begin
                if ($urandom_range(0, 7) == 0)
                    send_req(mk(KIND_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom), 0, zero_resp);
                if ($urandom_range(0, 9) == 0)
                    send_req(mk(KIND_READ, 0, 0, 0, 0, 0, 0, $urandom_range(0, 127)),
                             0, zero_resp);
                case ($urandom_range(0, 9))
                    0, 1: r = mk(KIND_LOAD, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                    2, 3: begin
                        r = mk(KIND_LOAD, $urandom_range(0, 65536), $urandom_range(0, 65536),
                               $urandom_range(0, 65536), $urandom_range(0, 65536),
                               $urandom_range(0, 65536), $urandom, 0);
                        if ($urandom_range(0, 3) == 0) r.cx = -r.cx;
                        if ($urandom_range(0, 3) == 0) r.h = -r.h;
                    end
                    default: r = mk(KIND_LOAD,
                                    ((bx + $urandom_range(0, 20)) << 16) | $urandom_range(0, 65535),
                                    ((by + $urandom_range(0, 20)) << 16) | $urandom_range(0, 65535),
                                    ($urandom_range(10, 100) << 16) | $urandom_range(0, 65535),
                                    ($urandom_range(10, 100) << 16) | $urandom_range(0, 65535),
                                    $urandom_range(0, 65536),
                                    (32'($urandom_range(0, 80)) << 15) ^
                                        ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0),
                                    $urandom);
                endcase
                send_req(r, 0, zero_resp);
            end
            if ($urandom_range(0, 9) != 0)
                send_req(mk(KIND_FINISH, $urandom, $urandom, 0, 0, 0, 0, $urandom), 0, zero_resp);
            nr = $urandom_range(2, 40);
            for (int i = 0; i < nr; i++) begin
                if ($urandom_range(0, 3) != 0)
                    r = mk(KIND_READ, 0, 0, 0, 0, 0, 0,
                           $urandom_range(0, (kept_num + 1 > 127) ? 127 : kept_num + 1));
                else
                    r = mk(KIND_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom_range(0, 127));
                send_req(r, 0, zero_resp);
            end
        end

        // fill the store with zero-size boxes and run past its end
        wait_idle();
        write_regs(16'd8192, 16'd8192, 16'd29491, 16'd128);
        while (box_total < BOX_CAP)
            send_req(mk(KIND_LOAD, $urandom, $urandom, 0, 0, 32'h8000_0000 | $urandom,
                        $urandom, $urandom), 0, zero_resp);
        for (int i = 0; i < 3; i++)
            send_req(mk(KIND_LOAD, $urandom, $urandom, 0, 0, 32'h8000_0000 | $urandom,
                        $urandom, 0), 0, zero_resp);
        send_req(mk(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0), 0, zero_resp);
        for (int i = 0; i < 40; i++)
            send_req(mk(KIND_READ, 0, 0, 0, 0, 0, 0, (i < 2) ? 127 * i : $urandom_range(0, 127)),
                     0, zero_resp);

        s_tvalid <= 1'b0;
        while (exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bdgn_pkg.sv
rtl/bdgn_ram.sv
rtl/box_decode_greedy_nms_core.sv
dv/tb_box_decode_greedy_nms_core.sv
